// ----- sv/fwtc_pkg.sv -----
package fwtc_pkg;

	localparam int REQ_W  = 2;
	localparam int ADDR_W = 8;
	localparam int WORD_W = 15;
	localparam int STAT_W = 2;

	localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] ST_HIT   = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS  = 2'd1;
	localparam logic [STAT_W-1:0] ST_ERROR = 2'd2;

	typedef struct packed {
		logic load;
		logic update;
	} dp_cmd_t;

	typedef struct packed {
		logic need_fill;
		logic is_clear;
	} dp_stat_t;

endpackage

// ----- sv/fwtc_ctrl.sv -----
module fwtc_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               out_stall,
	output logic               out_valid,
	output fwtc_pkg::dp_cmd_t  cmd,
	input  fwtc_pkg::dp_stat_t stat
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FILL = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load   = in_valid && (state_q == S_IDLE);
		cmd.update = ((state_q == S_EXEC && !stat.need_fill) || state_q == S_FILL) && out_free;
		state_d    = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid)
					state_d = S_EXEC;
			end
			S_EXEC: begin
				if (stat.need_fill)
					state_d = S_FILL;
				else if (out_free)
					state_d = S_IDLE;
			end
			S_FILL: begin
				if (out_free)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.update)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// fill only ever follows a read miss
	a_fill_needs_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> stat.need_fill)
		else $error("fill state without a read miss");

	// every finished request shows a result beat
	a_update_shows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> out_valid_q)
		else $error("result not presented after update");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == S_EXEC))
		else $error("accepted beat did not start execution");

endmodule

// ----- sv/fwtc_dp.sv -----
module fwtc_dp #(
	parameter int LINES     = 5,
	parameter int MEM_WORDS = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fwtc_pkg::dp_cmd_t             cmd,
	output fwtc_pkg::dp_stat_t            stat,
	input  logic [fwtc_pkg::REQ_W-1:0]    req_type,
	input  logic [fwtc_pkg::ADDR_W-1:0]   address,
	input  logic [fwtc_pkg::WORD_W-1:0]   write_data,
	output logic [fwtc_pkg::WORD_W-1:0]   read_data,
	output logic [fwtc_pkg::STAT_W-1:0]   status
);

	localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
	localparam int PW = (LINES > 1) ? $clog2(LINES) : 1;
	localparam logic [fwtc_pkg::ADDR_W:0] MEM_LIMIT = (fwtc_pkg::ADDR_W+1)'(MEM_WORDS);
	localparam logic [PW-1:0] PTR_LAST = PW'(LINES - 1);

	logic [fwtc_pkg::REQ_W-1:0]  req_q;
	logic [AW-1:0]               addr_q;
	logic                        range_q;
	logic [fwtc_pkg::WORD_W-1:0] wdata_q;

	logic [fwtc_pkg::WORD_W-1:0] mem [MEM_WORDS];
	logic [MEM_WORDS-1:0]        mem_vld_q;
	logic [fwtc_pkg::WORD_W-1:0] mem_word_q;
	logic                        mem_word_vld_q;
	logic [fwtc_pkg::WORD_W-1:0] mem_rd;

	logic [LINES-1:0]            valid_q;
	logic [AW-1:0]               tag_q  [LINES];
	logic [fwtc_pkg::WORD_W-1:0] word_q [LINES];
	logic [PW-1:0]               ptr_q;

	logic [fwtc_pkg::WORD_W-1:0] rdata_q;
	logic [fwtc_pkg::STAT_W-1:0] status_q;

	logic                        hit;
	logic [PW-1:0]               hit_idx;
	logic                        is_read;
	logic                        is_write;
	logic                        alloc;
	logic [fwtc_pkg::WORD_W-1:0] alloc_word;
	logic [fwtc_pkg::WORD_W-1:0] res_data;
	logic [fwtc_pkg::STAT_W-1:0] res_status;

	assign is_read  = (req_q == fwtc_pkg::REQ_READ) && range_q;
	assign is_write = (req_q == fwtc_pkg::REQ_WRITE) && range_q;
	assign mem_rd   = mem_word_vld_q ? mem_word_q : '0;

	// lowest matching line wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int i = LINES - 1; i >= 0; i--) begin
			if (valid_q[i] && tag_q[i] == addr_q) begin
				hit     = 1'b1;
				hit_idx = PW'(i);
			end
		end
	end

	assign stat.need_fill = is_read && !hit;
	assign stat.is_clear  = (req_q == fwtc_pkg::REQ_CLEAR);
	assign alloc          = (is_read || is_write) && !hit;
	assign alloc_word     = is_write ? wdata_q : mem_rd;

	always_comb begin
		res_data   = '0;
		res_status = fwtc_pkg::ST_HIT;
		if (req_q inside {fwtc_pkg::REQ_READ, fwtc_pkg::REQ_WRITE}) begin
			if (!range_q) begin
				res_status = fwtc_pkg::ST_ERROR;
			end else begin
				if (!hit)
					res_status = fwtc_pkg::ST_MISS;
				if (req_q == fwtc_pkg::REQ_READ)
					res_data = hit ? word_q[hit_idx] : mem_rd;
			end
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q   <= req_type;
			addr_q  <= address[AW-1:0];
			range_q <= ({1'b0, address} < MEM_LIMIT);
			wdata_q <= write_data;
		end
	end

	// backing store, registered read
	always_ff @(posedge clk) begin
		mem_word_q <= mem[addr_q];
		if (cmd.update && is_write)
			mem[addr_q] <= wdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mem_vld_q      <= '0;
			mem_word_vld_q <= 1'b0;
		end else begin
			mem_word_vld_q <= mem_vld_q[addr_q];
			if (cmd.update && is_write)
				mem_vld_q[addr_q] <= 1'b1;
		end
	end

	// line payload
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			if (alloc) begin
				tag_q[ptr_q]  <= addr_q;
				word_q[ptr_q] <= alloc_word;
			end else if (is_write) begin
				word_q[hit_idx] <= wdata_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			ptr_q   <= '0;
		end else if (cmd.update) begin
			if (stat.is_clear) begin
				valid_q <= '0;
			end else if (alloc) begin
				valid_q[ptr_q] <= 1'b1;
				ptr_q          <= (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rdata_q  <= res_data;
			status_q <= res_status;
		end
	end

	assign read_data = rdata_q;
	assign status    = status_q;

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update && stat.is_clear) |=> (valid_q == '0))
		else $error("lines still valid after clear");

endmodule

// ----- sv/fifo_write_through_cache_core.sv -----
// Fully associative write-through cache with FIFO replacement in front of an internal word
// store. A request beat is taken only when the block is idle. For a hit, a write, a clear or an
// address error the result is registered straight from the execute state; a read miss first
// passes through a fill state for the registered backing-store read, and its result is
// registered from there. Either way the result register waits while an earlier result is
// still held by out_stall. The next request is taken in the cycle after the result is
// registered, even while that result still waits on out_stall. The store reads as zero after
// reset through one valid flop per word, so no clearing pass is needed and requests are taken
// right out of reset.
module fifo_write_through_cache_core #(
	parameter int LINES     = 5,
	parameter int MEM_WORDS = 128
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [fwtc_pkg::REQ_W-1:0]  req_type,
	input  logic [fwtc_pkg::ADDR_W-1:0] address,
	input  logic [fwtc_pkg::WORD_W-1:0] write_data,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fwtc_pkg::WORD_W-1:0] read_data,
	output logic [fwtc_pkg::STAT_W-1:0] status
);

	fwtc_pkg::dp_cmd_t  cmd;
	fwtc_pkg::dp_stat_t stat;

	fwtc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.cmd       (cmd),
		.stat      (stat)
	);

	fwtc_dp #(
		.LINES     (LINES),
		.MEM_WORDS (MEM_WORDS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_type   (req_type),
		.address    (address),
		.write_data (write_data),
		.read_data  (read_data),
		.status     (status)
	);

endmodule
